/* rtl/core/plane_depth_error_stats_unit_macros.svh */
// Assertion macros shared by the RTL
`ifndef PLANE_DEPTH_ERROR_STATS_UNIT_MACROS_SVH
`define PLANE_DEPTH_ERROR_STATS_UNIT_MACROS_SVH

// Implication checked at every edge outside reset
`define PDES_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle
`define PDES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/pdes_pkg.sv */
package pdes_pkg;

    typedef struct packed {
        logic [9:0]         pixel_col;
        logic [9:0]         pixel_row;
        logic signed [31:0] measured_depth;
        logic               measured_valid;
        logic               last_pixel;
    } pdes_in_t;

    typedef struct packed {
        logic signed [31:0] rendered_depth;
        logic               render_valid;
        logic               stats_valid;
        logic [31:0]        error_mean;
        logic [31:0]        error_min;
        logic [31:0]        error_max;
        logic [20:0]        valid_count;
    } pdes_out_t;

    // Item passed from the render front to the statistics back
    typedef struct packed {
        logic signed [31:0] depth;
        logic               rok;
        logic signed [31:0] measured;
        logic               meas_ok;
        logic               last;
    } pdes_job_t;

    localparam logic [2:0] REG_NX = 3'd0;
    localparam logic [2:0] REG_NY = 3'd1;
    localparam logic [2:0] REG_NZ = 3'd2;
    localparam logic [2:0] REG_D  = 3'd3;
    localparam logic [2:0] REG_CX = 3'd4;
    localparam logic [2:0] REG_CY = 3'd5;
    localparam logic [2:0] REG_FX = 3'd6;
    localparam logic [2:0] REG_FY = 3'd7;

    localparam logic [51:0] SUM_MAX   = {52{1'b1}};
    localparam logic [20:0] COUNT_MAX = {21{1'b1}};

endpackage

/* rtl/core/pdes_divider.sv */
// Restoring signed divider, one quotient bit per cycle, truncates toward zero
module pdes_divider
    import pdes_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 64
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic signed [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic [NW-1:0] nmag;

    always_comb
    begin
        nmag      = num[NW-1] ? NW'(-num) : NW'(num);
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DW-1:0], q_reg[NW-1]};
        trial     = shifted - {1'b0, dmag_reg};
        if (start)
        begin
            q_next    = nmag;
            rem_next  = '0;
            dmag_next = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next  = num[NW-1] ^ den[DW-1];
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? NW'(-q_reg) : NW'(q_reg);
endmodule

/* rtl/core/pdes_front.sv */
// Render front: forms the ray denominator and divides for the plane depth
`include "plane_depth_error_stats_unit_macros.svh"
module pdes_front
    import pdes_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] nx,
    input  logic signed [31:0] ny,
    input  logic signed [31:0] nz,
    input  logic signed [31:0] pd,
    input  logic [23:0]        cx,
    input  logic [23:0]        cy,
    input  logic [23:0]        fx,
    input  logic [23:0]        fy,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdes_in_t           in_data,
    output logic               job_valid,
    input  logic               job_ready,
    output pdes_job_t          job_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIVT = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_DIVD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         st_reg, st_next;
    pdes_in_t           it_reg;
    logic               inb_reg;
    logic signed [57:0] py_reg;
    logic signed [63:0] tx_reg, den_reg;
    logic               rok_reg;
    logic signed [31:0] depth_reg;

    logic signed [24:0] dx, dy;
    logic signed [57:0] px;
    logic               div_start, div_busy, div_done;
    logic signed [63:0] div_num, div_den, div_quot;
    logic               dsel_reg;
    logic signed [63:0] dq_sat;

    assign dx = $signed({1'b0, it_reg.pixel_col, 8'd0}) - $signed({1'b0, cx});
    assign dy = $signed({1'b0, it_reg.pixel_row, 8'd0}) - $signed({1'b0, cy});
    // nx*dx feeds the divider directly when the first division starts
    assign px = nx * dx;

    // One divider shared by term_x, term_y and the depth division
    pdes_divider #(.NW(64), .DW(64)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .done(div_done), .quot(div_quot)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_num   = 64'(px);
        div_den   = $signed({40'd0, fx});
        unique case (st_reg)
            S_MUL:  div_start = 1'b1;
            S_DIVT:
            begin
                div_start = div_done && !dsel_reg;
                div_num   = 64'(py_reg);
                div_den   = $signed({40'd0, fy});
            end
            S_SUM:
            begin
                div_start = den_reg != 64'sd0;
                div_num   = -($signed(64'(pd)) <<< 30);
                div_den   = den_reg;
            end
            default: ;
        endcase
    end

    assign dq_sat = div_quot;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (in_valid) st_next = S_MUL;
            S_MUL:  st_next = S_DIVT;
            S_DIVT: if (div_done && dsel_reg) st_next = S_SUM;
            S_SUM:  st_next = (den_reg != 64'sd0) ? S_DIVD : S_OUT;
            S_DIVD: if (div_done) st_next = S_OUT;
            S_OUT:  if (job_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            dsel_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_MUL)
                dsel_reg <= 1'b0;
            else if (st_reg == S_DIVT && div_done)
                dsel_reg <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid)
        begin
            it_reg  <= in_data;
            inb_reg <= (32'(in_data.pixel_col) < 32'(MAX_WIDTH))
                    && (32'(in_data.pixel_row) < 32'(MAX_HEIGHT));
        end
        if (st_reg == S_IDLE)
            py_reg <= '0;
        else if (st_reg == S_MUL)
            py_reg <= ny * dy;
        if (st_reg == S_DIVT && div_done && !dsel_reg)
            tx_reg <= div_quot;
        if (st_reg == S_DIVT && div_done && dsel_reg)
            den_reg <= tx_reg + div_quot + 64'(nz);
        if (st_reg == S_SUM)
        begin
            rok_reg   <= inb_reg && (fx != 24'd0) && (fy != 24'd0)
                      && (den_reg != 64'sd0);
            depth_reg <= '0;
        end
        if (st_reg == S_DIVD && div_done)
        begin
            if (dq_sat > 64'sd2147483647)
                depth_reg <= 32'sh7fffffff;
            else if (dq_sat < -64'sd2147483648)
                depth_reg <= 32'sh80000000;
            else
                depth_reg <= dq_sat[31:0];
        end
    end

    assign in_ready  = st_reg == S_IDLE;
    assign job_valid = st_reg == S_OUT;
    always_comb
    begin
        job_data.depth    = rok_reg ? depth_reg : 32'sd0;
        job_data.rok      = rok_reg;
        job_data.measured = it_reg.measured_depth;
        job_data.meas_ok  = it_reg.measured_valid;
        job_data.last     = it_reg.last_pixel;
    end

    `PDES_ASSERT_IMP(a_div_idle_in, st_reg == S_IDLE, !div_busy)
    `PDES_ASSERT_IMP(a_out_norok_zero, job_valid && !rok_reg, job_data.depth == 32'sd0)
    `PDES_ASSERT_NEXT(a_mul_to_div, st_reg == S_MUL, div_busy)
endmodule

/* rtl/core/pdes_queue.sv */
// Two-entry queue between front and back
`include "plane_depth_error_stats_unit_macros.svh"
module pdes_queue
    import pdes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  pdes_job_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output pdes_job_t rd_data
);
    pdes_job_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_xfer, rd_xfer;

    assign wr_xfer  = wr_valid && wr_ready;
    assign rd_xfer  = rd_valid && rd_ready;
    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_xfer) wp_reg <= ~wp_reg;
            if (rd_xfer) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_xfer) - 2'(rd_xfer);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_xfer)
            mem_reg[wp_reg] <= wr_data;
    end

    `PDES_ASSERT_IMP(a_no_overflow, cnt_reg == 2'd2, !wr_xfer)
    `PDES_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg != 2'd3)
    `PDES_ASSERT_NEXT(a_fill, wr_xfer && !rd_xfer && cnt_reg == 2'd0, rd_valid)
endmodule

/* rtl/core/pdes_back.sv */
// Statistics back: error, running min/max/sum/count, mean on last pixel
`include "plane_depth_error_stats_unit_macros.svh"
module pdes_back
    import pdes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  pdes_job_t job_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pdes_out_t out_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;

    logic [1:0]  st_reg;
    logic [51:0] sum_reg;
    logic [31:0] min_reg, max_reg;
    logic [20:0] cnt_reg;
    pdes_out_t   res_reg;

    logic signed [32:0] diff;
    logic [31:0]        err;
    logic               ok;
    logic [52:0]        sum_w;
    logic [51:0]        sum_n;
    logic [20:0]        cnt_n;
    logic [31:0]        min_n, max_n;
    logic               div_start, div_busy, div_done;
    logic signed [53:0] div_quot;

    assign ok    = job_data.rok && job_data.meas_ok;
    assign diff  = 33'(job_data.depth) - 33'(job_data.measured);
    assign err   = ok ? (diff[32] ? 32'(-diff) : diff[31:0]) : 32'd0;
    assign sum_w = {1'b0, sum_reg} + 53'(err);
    assign sum_n = sum_w[52] ? SUM_MAX : sum_w[51:0];
    assign cnt_n = (ok && cnt_reg != COUNT_MAX) ? cnt_reg + 21'd1 : cnt_reg;
    assign min_n = (err < min_reg) ? err : min_reg;
    assign max_n = (err > max_reg) ? err : max_reg;

    // Mean divider, sum over count; not started for an empty frame
    pdes_divider #(.NW(54), .DW(23)) u_mean (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num($signed({2'b00, sum_reg})), .den($signed({2'b00, cnt_reg})),
        .busy(div_busy), .done(div_done), .quot(div_quot)
    );
    assign div_start = st_reg == S_DIV && !div_busy && !div_done && cnt_reg != 21'd0;

    assign job_ready = st_reg == S_IDLE && (!res_reg.stats_valid || !out_valid)
                    && !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            sum_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            cnt_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (job_valid && job_ready)
                    begin
                        sum_reg <= sum_n;
                        min_reg <= min_n;
                        max_reg <= max_n;
                        cnt_reg <= cnt_n;
                        if (job_data.last)
                            st_reg <= S_DIV;
                        else
                            out_valid <= 1'b1;
                    end
                S_DIV:
                    if (div_done || cnt_reg == 21'd0)
                    begin
                        st_reg    <= S_IDLE;
                        out_valid <= 1'b1;
                        sum_reg   <= '0;
                        min_reg   <= '1;
                        max_reg   <= '0;
                        cnt_reg   <= '0;
                    end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && job_valid && job_ready)
        begin
            res_reg.rendered_depth <= job_data.depth;
            res_reg.render_valid   <= job_data.rok;
            res_reg.stats_valid    <= job_data.last;
            res_reg.error_mean     <= '0;
            res_reg.error_min      <= job_data.last ? min_n : 32'd0;
            res_reg.error_max      <= job_data.last ? max_n : 32'd0;
            res_reg.valid_count    <= job_data.last ? cnt_n : 21'd0;
        end
        else if (st_reg == S_DIV && (div_done || cnt_reg == 21'd0))
        begin
            if (cnt_reg == 21'd0)
                res_reg.error_mean <= '0;
            else if (div_quot[53:32] != 22'd0)
                res_reg.error_mean <= '1;
            else
                res_reg.error_mean <= div_quot[31:0];
        end
    end

    assign out_data = res_reg;

    `PDES_ASSERT_IMP(a_no_accept_busy, st_reg != S_IDLE, !job_ready)
    `PDES_ASSERT_IMP(a_minmax, cnt_reg != 21'd0, min_reg <= max_reg)
    `PDES_ASSERT_NEXT(a_clear, st_reg == S_DIV && cnt_reg == 21'd0, out_valid)
endmodule

/* rtl/core/plane_depth_error_stats_unit.sv */
// Channel | Dir | Signals
// in      | in  | in_valid, in_ready, in_data (pdes_in_t)
// out     | out | out_valid, out_ready, out_data (pdes_out_t)
// cfg     | in  | cfg_we, cfg_index, cfg_data
// Front: takes one pixel at a time, with up to three 64-bit divisions on one shared divider.
// Back: accepts a pixel, then waits for its output transfer before accepting the next; on
// the last pixel the mean division (skipped when no pixel was valid) comes in between.
// A two-entry queue lets the front render while the back waits on out_ready.
// Reset (rst_n, async low) clears all control and loads the default plane and intrinsics.
`include "plane_depth_error_stats_unit_macros.svh"
module plane_depth_error_stats_unit
    import pdes_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pdes_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pdes_out_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic signed [31:0] nx_reg, ny_reg, nz_reg, pd_reg;
    logic [23:0]        cx_reg, cy_reg, fx_reg, fy_reg;
    logic               fj_valid, fj_ready, bj_valid, bj_ready;
    pdes_job_t          fj_data, bj_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= 32'sh40000000;
            pd_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            fx_reg <= 24'd256;
            fy_reg <= 24'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NX: nx_reg <= cfg_data;
                REG_NY: ny_reg <= cfg_data;
                REG_NZ: nz_reg <= cfg_data;
                REG_D:  pd_reg <= cfg_data;
                REG_CX: cx_reg <= cfg_data[23:0];
                REG_CY: cy_reg <= cfg_data[23:0];
                REG_FX: fx_reg <= cfg_data[23:0];
                REG_FY: fy_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    pdes_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .nx(nx_reg), .ny(ny_reg), .nz(nz_reg),
        .pd(pd_reg), .cx(cx_reg), .cy(cy_reg), .fx(fx_reg), .fy(fy_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
    );

    pdes_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready),
        .wr_data(fj_data), .rd_valid(bj_valid), .rd_ready(bj_ready),
        .rd_data(bj_data)
    );

    pdes_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready),
        .job_data(bj_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    `PDES_ASSERT_IMP(a_norender_zero, out_valid && !out_data.render_valid,
        out_data.rendered_depth == 32'sd0)
    `PDES_ASSERT_IMP(a_nostats_zero, out_valid && !out_data.stats_valid,
        out_data.valid_count == 21'd0)
    `PDES_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule
